// ===== hw/rtl/qmm_pkg.sv =====
`timescale 1ns / 1ps

package qmm_pkg;

   // field widths
   localparam int STICK_W    = 10;
   localparam int THR_W      = 11;
   localparam int GYRO_W     = 10;
   localparam int GAIN_W     = 10;
   localparam int TIME_W     = 16;
   localparam int MOTOR_W    = 12;
   localparam int EVENT_W    = 3;
   localparam int TERM_W     = 11;   // gyro correction, within +-639
   localparam int MIX_W      = 14;   // motor sum before the floor

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // mixer constants
   localparam int GYRO_LIMIT  = 500;
   localparam int MOTOR_FLOOR = 10;
   localparam int PLUS_HOLD   = 16;

   // divide by 800 as (x >> 5) / 25, the /25 by reciprocal multiply
   localparam int DIV_PRE_SHIFT = 5;
   localparam int RECIP_SHIFT   = 19;
   localparam int RECIP_25      = (1 << RECIP_SHIFT) / 25 + 1;

   // register reset values
   localparam logic signed [THR_W-1:0]   ARM_LEVEL_RST   = 11'sd5;
   localparam logic signed [STICK_W-1:0] LEFT_LEVEL_RST  = -10'sd100;
   localparam logic signed [STICK_W-1:0] RIGHT_LEVEL_RST = 10'sd100;
   localparam logic [TIME_W-1:0]         HOLD_TICKS_RST  = 16'd100;
   localparam logic [2:0]                GYRO_REV_RST    = 3'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARM_LEVEL   = 3'd0,
      CSR_LEFT_LEVEL  = 3'd1,
      CSR_RIGHT_LEVEL = 3'd2,
      CSR_HOLD_TICKS  = 3'd3,
      CSR_GYRO_REV    = 3'd4
   } csr_index_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE     = 3'd0,
      EV_ARMED    = 3'd1,
      EV_DISARMED = 3'd2,
      EV_X_MODE   = 3'd3,
      EV_PLUS     = 3'd4
   } event_type;

   // input item, last field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]         time_now;
      logic [GAIN_W-1:0]         gain_yaw_pot;
      logic [GAIN_W-1:0]         gain_pitch_pot;
      logic signed [GYRO_W-1:0]  gyro_yaw;
      logic signed [GYRO_W-1:0]  gyro_pitch;
      logic signed [GYRO_W-1:0]  gyro_roll;
      logic signed [THR_W-1:0]   throttle_stick;
      logic signed [STICK_W-1:0] yaw_stick;
      logic signed [STICK_W-1:0] pitch_stick;
      logic signed [STICK_W-1:0] roll_stick;
   } req_type;

   localparam int REQ_USED_W = $bits(req_type);

   typedef struct packed {
      logic [EVENT_W-1:0] event_code;
      logic               is_x_mode;
      logic               is_armed;
      logic [MOTOR_W-1:0] motor_rear;
      logic [MOTOR_W-1:0] motor_right;
      logic [MOTOR_W-1:0] motor_left;
      logic [MOTOR_W-1:0] motor_front;
   } rsp_type;

   localparam int RSP_USED_W = $bits(rsp_type);

endpackage

// ===== hw/rtl/qmm_gyro_term.sv =====
`timescale 1ns / 1ps

// Gyro correction: clamp to +-500, times gain, /800 toward zero, optional invert.
module qmm_gyro_term (
   input  logic signed [qmm_pkg::GYRO_W-1:0] gyro,
   input  logic [qmm_pkg::GAIN_W-1:0]        gain,
   input  logic                              invert,
   output logic signed [qmm_pkg::TERM_W-1:0] term
);
   import qmm_pkg::*;

   localparam int MAG_W  = GYRO_W - 1;                 // |clamped| <= 500
   localparam int PROD_W = MAG_W + GAIN_W;
   localparam int PRE_W  = PROD_W - DIV_PRE_SHIFT;
   localparam int RCP_W  = $clog2(RECIP_25 + 1);
   localparam int QP_W   = PRE_W + RCP_W;
   localparam int Q_W    = TERM_W - 1;

   logic [MAG_W-1:0]  mag;
   logic              neg;
   logic [PROD_W-1:0] prod;
   logic [PRE_W-1:0]  pre;
   logic [QP_W-1:0]   qprod;
   logic [Q_W-1:0]    quot;

   always_comb begin
      neg = gyro[GYRO_W-1];
      if (gyro > GYRO_W'(GYRO_LIMIT) || gyro < -GYRO_W'(GYRO_LIMIT)) begin
         mag = MAG_W'(GYRO_LIMIT);
      end else if (neg) begin
         mag = MAG_W'(-gyro);
      end else begin
         mag = MAG_W'(gyro);
      end
      prod  = PROD_W'(mag) * PROD_W'(gain);
      pre   = prod[PROD_W-1:DIV_PRE_SHIFT];
      qprod = QP_W'(pre) * QP_W'(RECIP_25);
      quot  = qprod[RECIP_SHIFT +: Q_W];
      if (neg ^ invert) begin
         term = -$signed({1'b0, quot});
      end else begin
         term = $signed({1'b0, quot});
      end
   end

endmodule

// ===== hw/rtl/quad_motor_mixer_with_arming.sv =====
`timescale 1ns / 1ps

// Quad motor mixer with stick arming and plus/X frame selection.
// req_: one transfer per control tick carrying sticks, gyro rates, gain pots
//   and the free-running timer value. rsp_: one transfer per tick with the
//   four motor commands, the armed and X-mode status and an event code.
// csr_: register writes (index, data), always ready; write only while idle.
// Datapath: input register -> one pass of clamp/multiply/divide/mix and the
//   arm state machine -> result register. The arm, mode and hold snapshot
//   state updates as the item moves into the result register.
// The gyro multiply plus reciprocal divide is the longest path. Throughput: one
//   item per cycle if rsp_tready is high; the result register drives rsp_tvalid.
// Reset: disarmed, plus frame, no hold running, registers at their defaults,
//   both pipeline registers empty.
// Stall: while rsp_tready is low the result holds; the input register still
//   takes one more item, then req_tready drops until the result is taken.
// Motors read 0 whenever the throttle is down or the block is disarmed, and
//   never below 10 when flying.
module quad_motor_mixer_with_arming (
   input  logic                              clock,
   input  logic                              reset,
   // roll_stick, pitch_stick, yaw_stick, throttle_stick, gyro_roll,
   // gyro_pitch, gyro_yaw, gain_pitch_pot, gain_yaw_pot, time_now, pad
   input  logic [qmm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // motor_front, motor_left, motor_right, motor_rear, is_armed,
   // is_x_mode, event_code, pad
   output logic [qmm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qmm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qmm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import qmm_pkg::*;

   // configuration registers
   logic signed [THR_W-1:0]   arm_level_ff;
   logic signed [STICK_W-1:0] left_level_ff;
   logic signed [STICK_W-1:0] right_level_ff;
   logic [TIME_W-1:0]         hold_ticks_ff;
   logic [2:0]                gyro_rev_ff;

   // pipeline
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    advance;

   // flight state
   logic              armed_ff, armed_in;
   logic              x_mode_ff, x_mode_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;

   // hold / arming logic
   logic              thr_down;
   logic [TIME_W-1:0] elapsed;
   logic              over_hold, over_plus;
   logic              c_disarm, c_arm, c_xmode, c_plus;
   logic              d_disarm, d_arm, d_xmode, d_plus;
   logic              armed_mid, armed_fin;
   logic              holding;
   event_type         event_code;

   // mixer
   logic signed [TERM_W-1:0]  term_roll, term_pitch, term_yaw;
   logic signed [MIX_W-1:0]   t, cr, cp, cy, fr, fp, fy;
   logic signed [MIX_W-1:0]   mix [4];
   logic [MOTOR_W-1:0]        motor [4];
   logic                      flying;

   assign csr_ready  = 1'b1;
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_level_ff   <= ARM_LEVEL_RST;
         left_level_ff  <= LEFT_LEVEL_RST;
         right_level_ff <= RIGHT_LEVEL_RST;
         hold_ticks_ff  <= HOLD_TICKS_RST;
         gyro_rev_ff    <= GYRO_REV_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ARM_LEVEL:   arm_level_ff   <= csr_data[THR_W-1:0];
            CSR_LEFT_LEVEL:  left_level_ff  <= csr_data[STICK_W-1:0];
            CSR_RIGHT_LEVEL: right_level_ff <= csr_data[STICK_W-1:0];
            CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_data[TIME_W-1:0];
            CSR_GYRO_REV:    gyro_rev_ff    <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // ---- arm / disarm and frame select, evaluated in model order ----
   always_comb begin
      thr_down  = s1_ff.throttle_stick < arm_level_ff;
      elapsed   = hold_valid_ff ? (s1_ff.time_now - hold_start_ff) : '0;
      over_hold = elapsed > hold_ticks_ff;
      over_plus = elapsed > TIME_W'(PLUS_HOLD);

      c_disarm  = thr_down && armed_ff && (s1_ff.yaw_stick < left_level_ff);
      d_disarm  = c_disarm && over_hold;
      armed_mid = armed_ff && !d_disarm;

      // after a change the snapshot restarts at now, so no second change
      c_arm     = thr_down && !armed_mid && (s1_ff.yaw_stick > right_level_ff);
      d_arm     = c_arm && !d_disarm && over_hold;
      armed_fin = armed_mid || d_arm;

      c_xmode   = thr_down && !armed_fin && (s1_ff.roll_stick > right_level_ff);
      c_plus    = thr_down && !armed_fin && !c_xmode
                  && (s1_ff.roll_stick < left_level_ff);
      d_xmode   = c_xmode && !d_disarm && over_hold;
      d_plus    = c_plus && !d_disarm && over_plus;

      holding   = c_disarm || c_arm || c_xmode || c_plus;

      armed_in  = armed_fin;
      x_mode_in = d_xmode ? 1'b1 : (d_plus ? 1'b0 : x_mode_ff);

      if (!holding) begin
         hold_valid_in = 1'b0;
         hold_start_in = '0;
      end else if (d_disarm && (c_arm || c_xmode || c_plus)) begin
         hold_valid_in = 1'b1;           // later hold in the same tick re-snaps
         hold_start_in = s1_ff.time_now;
      end else if (d_disarm || d_arm || d_xmode || d_plus) begin
         hold_valid_in = 1'b0;
         hold_start_in = '0;
      end else begin
         hold_valid_in = 1'b1;
         hold_start_in = hold_valid_ff ? hold_start_ff : s1_ff.time_now;
      end

      if (d_arm) begin
         event_code = EV_ARMED;
      end else if (d_disarm) begin
         event_code = EV_DISARMED;
      end else if (d_xmode) begin
         event_code = EV_X_MODE;
      end else if (d_plus) begin
         event_code = EV_PLUS;
      end else begin
         event_code = EV_NONE;
      end
   end

   // ---- gyro corrections ----
   qmm_gyro_term u_term_roll (
      .gyro   (s1_ff.gyro_roll),
      .gain   (s1_ff.gain_pitch_pot),
      .invert (gyro_rev_ff[0]),
      .term   (term_roll)
   );

   qmm_gyro_term u_term_pitch (
      .gyro   (s1_ff.gyro_pitch),
      .gain   (s1_ff.gain_pitch_pot),
      .invert (gyro_rev_ff[1]),
      .term   (term_pitch)
   );

   qmm_gyro_term u_term_yaw (
      .gyro   (s1_ff.gyro_yaw),
      .gain   (s1_ff.gain_yaw_pot),
      .invert (gyro_rev_ff[2]),
      .term   (term_yaw)
   );

   // ---- motor mix ----
   always_comb begin
      flying = !thr_down && armed_ff;
      t  = MIX_W'(s1_ff.throttle_stick);
      cr = MIX_W'(term_roll);
      cp = MIX_W'(term_pitch);
      cy = MIX_W'(term_yaw);
      fr = MIX_W'(s1_ff.roll_stick >>> 2);   // floor shift
      fp = MIX_W'(s1_ff.pitch_stick >>> 2);
      fy = MIX_W'(s1_ff.yaw_stick >>> 2);

      if (x_mode_ff) begin
         mix[0] = t - cp + cy + fr + fp - fy;
         mix[1] = t - cr - cy + fr - fp + fy;
         mix[2] = t + cr - cy - fr + fp + fy;
         mix[3] = t + cp + cy - fr - fp - fy;
      end else begin
         mix[0] = t - cp + cy + fp - fy;
         mix[1] = t - cr - cy + fr + fy;
         mix[2] = t + cr - cy - fr + fy;
         mix[3] = t + cp + cy - fp - fy;
      end

      for (int i = 0; i < 4; i++) begin
         if (!flying) begin
            motor[i] = '0;
         end else if (mix[i] < MIX_W'(MOTOR_FLOOR)) begin
            motor[i] = MOTOR_W'(MOTOR_FLOOR);
         end else begin
            motor[i] = mix[i][MOTOR_W-1:0];
         end
      end

      rsp_in.motor_front = motor[0];
      rsp_in.motor_left  = motor[1];
      rsp_in.motor_right = motor[2];
      rsp_in.motor_rear  = motor[3];
      rsp_in.is_armed    = armed_fin;
      rsp_in.is_x_mode   = x_mode_in;
      rsp_in.event_code  = event_code;
   end

   // ---- handshake control ----
   always_comb begin
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         armed_ff      <= 1'b0;
         x_mode_ff     <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_start_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            armed_ff      <= armed_in;
            x_mode_ff     <= x_mode_in;
            hold_valid_ff <= hold_valid_in;
            hold_start_ff <= hold_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_ff <= req_tdata[REQ_USED_W-1:0];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
